// File: src/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants for the alias table sampler: word layouts of
// both channels, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    // default sizing
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_WEIGHT_BITS = 16;

    // fixed point fraction of the uniform input
    localparam int FRAC_BITS = 16;

    // item opcodes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_SAMPLE = 2'd2
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO_SUM  = 2'd1,
        STAT_NOT_BUILT = 2'd2
    } status_t;

    // input word
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  entry_index;
        logic [15:0] weight;
        logic [15:0] uniform;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] sampled_index;
        logic [1:0] status;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SUM,
        S_SUM_CHK,
        S_SCALE,
        S_POP,
        S_RD_Q,
        S_UPD,
        S_LEFT_O,
        S_LEFT_U,
        S_SMP_IDX,
        S_SMP_MUL,
        S_SMP_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: src/alias_table_sampler.sv
// ----------------------------------------------------------------------------
// alias_table_sampler
// Vose alias sampler built around block memories for weights, thresholds,
// aliases and the two work stacks, driven by one sequencer.
// ----------------------------------------------------------------------------
// Every word gets exactly one result word. A load shows its result word
// before the next word can be taken; a sample takes an index multiply,
// one table read, a split multiply of the fraction by the weight sum and
// a compare. A build is bounded by memory passes over n = entry_count
// entries: one sum pass and one scale pass, then pairing steps (stack
// read, threshold read, write back), at most n-1 steps, then a fix-up pass
// over the leftover stack entries. After reset the weight memory is
// cleared one entry a cycle, during which no word is taken; configuration
// writes are taken at any time. A finished result waits in the output
// register while the next word is accepted.
`default_nettype none

module alias_table_sampler
    import ats_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_wr_en,
    input  wire logic [8:0] cfg_wr_data,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int WB = WEIGHT_BITS;
    localparam int QW = WB + NW;
    localparam int HL = (QW + 1) / 2;
    localparam int HH = QW - HL;
    localparam int PW = QW + FRAC_BITS + 1;

    // memories
    logic [WB-1:0] wmem [MAX_ENTRIES];
    logic [QW-1:0] qmem [MAX_ENTRIES];
    logic [IW-1:0] amem [MAX_ENTRIES];
    logic [IW-1:0] omem [MAX_ENTRIES];
    logic [IW-1:0] umem [MAX_ENTRIES];

    logic          we_w, we_q, we_a, we_o, we_u;
    logic [IW-1:0] wa_w, wa_q, wa_a, wa_o, wa_u;
    logic [WB-1:0] wd_w;
    logic [QW-1:0] wd_q;
    logic [IW-1:0] wd_a, wd_o, wd_u;
    logic [IW-1:0] ra_w, ra_q0, ra_q1, ra_a, ra_o, ra_u;
    logic [WB-1:0] rd_w;
    logic [QW-1:0] rd_q0, rd_q1;
    logic [IW-1:0] rd_a, rd_o, rd_u;

    // state
    state_t           state_reg, state_next;
    in_word_t         item_reg, item_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             pv_reg, pv_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic [QW-1:0]    sum_reg, sum_next;
    logic [NW-1:0]    no_reg, no_next;
    logic [NW-1:0]    nu_reg, nu_next;
    logic             built_reg, built_next;
    logic [8:0]       ecount_reg, ecount_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [15:0]      frac_reg, frac_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [IW-1:0]    alias_reg, alias_next;
    logic [FRAC_BITS+HL-1:0] lo_reg, lo_next;
    logic [FRAC_BITS+HH-1:0] hi_reg, hi_next;
    logic [IW-1:0]    ov_reg, ov_next;
    logic [IW-1:0]    un_reg, un_next;
    status_t          stat_reg, stat_next;
    logic [IW-1:0]    sel_reg, sel_next;
    out_word_t        out_reg, out_next;
    logic             mv_reg, mv_next;

    // datapath helpers
    logic [NW-1:0]        n_act;
    logic [NW+15:0]       x_full;
    logic [NW-1:0]        x_int;
    logic [NW-1:0]        idx_wide;
    logic [QW-1:0]        scale_q;
    logic [QW:0]          pair_q_wide;
    logic [QW-1:0]        pair_q;
    logic [PW-1:0]        prod;
    logic [QW+15:0]       q_shift;
    logic                 take_idx;
    logic [NW-1:0]        no_dec, nu_dec;
    logic [31:0]          w_ext, ld_ext, sel_ext;
    logic                 out_free;

    // memory ports
    always_ff @(posedge aclk) begin
        if (we_w) begin
            wmem[wa_w] <= wd_w;
        end
        if (we_q) begin
            qmem[wa_q] <= wd_q;
        end
        if (we_a) begin
            amem[wa_a] <= wd_a;
        end
        if (we_o) begin
            omem[wa_o] <= wd_o;
        end
        if (we_u) begin
            umem[wa_u] <= wd_u;
        end
        rd_w  <= wmem[ra_w];
        rd_q0 <= qmem[ra_q0];
        rd_q1 <= qmem[ra_q1];
        rd_a  <= amem[ra_a];
        rd_o  <= omem[ra_o];
        rd_u  <= umem[ra_u];
    end

    // active entry count, clamped into 1..MAX_ENTRIES
    always_comb begin
        if (ecount_reg == 9'd0) begin
            n_act = NW'(1);
        end else if ({23'd0, ecount_reg} > 32'(MAX_ENTRIES)) begin
            n_act = NW'(MAX_ENTRIES);
        end else begin
            n_act = NW'(ecount_reg);
        end
    end

    // arithmetic
    assign x_full      = (NW+16)'(n_act) * (NW+16)'(item_reg.uniform);
    assign x_int       = x_full[NW+15:16];
    assign idx_wide    = (x_int > n_act - 1'b1) ? n_act - 1'b1 : x_int;
    assign scale_q     = QW'(rd_w) * QW'(n_act);
    assign pair_q_wide = {1'b0, rd_q0} + {1'b0, rd_q1} - {1'b0, sum_reg};
    assign pair_q      = pair_q_wide[QW-1:0];
    assign prod        = (PW'(hi_reg) << HL) + PW'(lo_reg);
    assign q_shift     = {q_reg, 16'd0};
    assign take_idx    = (q_reg >= sum_reg) || (prod <= PW'(q_shift));
    assign no_dec      = no_reg - 1'b1;
    assign nu_dec      = nu_reg - 1'b1;
    assign w_ext       = {16'd0, item_reg.weight};
    assign ld_ext      = {24'd0, item_reg.entry_index};
    assign sel_ext     = 32'(sel_reg);
    assign out_free    = !mv_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == NW'(MAX_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (item_reg.opcode)
                    OP_BUILD:  state_next = S_SUM;
                    OP_SAMPLE: state_next = built_reg ? S_SMP_IDX : S_DONE;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SUM: begin
                if (cnt_reg >= n_act && !pv_reg) begin
                    state_next = S_SUM_CHK;
                end
            end
            S_SUM_CHK: begin
                state_next = (sum_reg == '0) ? S_DONE : S_SCALE;
            end
            S_SCALE: begin
                if (cnt_reg >= n_act && !pv_reg) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                state_next = (no_reg == '0 || nu_reg == '0) ? S_LEFT_O : S_RD_Q;
            end
            S_RD_Q:    state_next = S_UPD;
            S_UPD:     state_next = S_POP;
            S_LEFT_O: begin
                if (cnt_reg >= no_reg && !pv_reg) begin
                    state_next = S_LEFT_U;
                end
            end
            S_LEFT_U: begin
                if (cnt_reg >= nu_reg && !pv_reg) begin
                    state_next = S_DONE;
                end
            end
            S_SMP_IDX: state_next = S_SMP_MUL;
            S_SMP_MUL: state_next = S_SMP_CMP;
            S_SMP_CMP: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        item_next   = item_reg;
        cnt_next    = cnt_reg;
        pv_next     = 1'b0;
        pidx_next   = cnt_reg[IW-1:0];
        sum_next    = sum_reg;
        no_next     = no_reg;
        nu_next     = nu_reg;
        built_next  = built_reg;
        ecount_next = ecount_reg;
        idx_next    = idx_reg;
        frac_next   = frac_reg;
        q_next      = q_reg;
        alias_next  = alias_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ov_next     = ov_reg;
        un_next     = un_reg;
        stat_next   = stat_reg;
        sel_next    = sel_reg;
        out_next    = out_reg;
        mv_next     = mv_reg && !m_ready;

        we_w = 1'b0; wa_w = cnt_reg[IW-1:0]; wd_w = '0;
        we_q = 1'b0; wa_q = pidx_reg;        wd_q = scale_q;
        we_a = 1'b0; wa_a = pidx_reg;        wd_a = pidx_reg;
        we_o = 1'b0; wa_o = no_reg[IW-1:0];  wd_o = pidx_reg;
        we_u = 1'b0; wa_u = nu_reg[IW-1:0];  wd_u = pidx_reg;
        ra_w  = cnt_reg[IW-1:0];
        ra_q0 = idx_wide[IW-1:0];
        ra_q1 = rd_u;
        ra_a  = idx_wide[IW-1:0];
        ra_o  = cnt_reg[IW-1:0];
        ra_u  = cnt_reg[IW-1:0];

        unique case (state_reg)
            // zero the weight memory after reset
            S_CLEAR: begin
                we_w     = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            // dispatch
            S_EXEC: begin
                stat_next = STAT_OK;
                sel_next  = '0;
                cnt_next  = '0;
                case (item_reg.opcode)
                    OP_LOAD: begin
                        if (ld_ext < 32'(MAX_ENTRIES)) begin
                            we_w = 1'b1;
                            wa_w = ld_ext[IW-1:0];
                            wd_w = w_ext[WB-1:0];
                        end
                        built_next = 1'b0;
                    end
                    OP_BUILD: begin
                        sum_next = '0;
                    end
                    OP_SAMPLE: begin
                        if (!built_reg) begin
                            stat_next = STAT_NOT_BUILT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // sum pass
            S_SUM: begin
                if (cnt_reg < n_act) begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                if (pv_reg) begin
                    sum_next = sum_reg + QW'(rd_w);
                end
            end
            S_SUM_CHK: begin
                cnt_next = '0;
                no_next  = '0;
                nu_next  = '0;
                if (sum_reg == '0) begin
                    stat_next  = STAT_ZERO_SUM;
                    built_next = 1'b0;
                end
            end
            // scale pass and stack split in index order
            S_SCALE: begin
                if (cnt_reg < n_act) begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                if (pv_reg) begin
                    we_q = 1'b1;
                    we_a = 1'b1;
                    if (scale_q > sum_reg) begin
                        we_o    = 1'b1;
                        no_next = no_reg + 1'b1;
                    end else if (scale_q < sum_reg) begin
                        we_u    = 1'b1;
                        nu_next = nu_reg + 1'b1;
                    end
                end
            end
            // pop both stack tops
            S_POP: begin
                cnt_next = '0;
                if (no_reg != '0 && nu_reg != '0) begin
                    ra_o    = no_dec[IW-1:0];
                    ra_u    = nu_dec[IW-1:0];
                    no_next = no_dec;
                    nu_next = nu_dec;
                end
            end
            // read both thresholds
            S_RD_Q: begin
                ov_next = rd_o;
                un_next = rd_u;
                ra_q0   = rd_o;
                ra_q1   = rd_u;
            end
            // move excess of the over entry, alias the under entry
            S_UPD: begin
                we_q = 1'b1;
                wa_q = ov_reg;
                wd_q = pair_q;
                we_a = 1'b1;
                wa_a = un_reg;
                wd_a = ov_reg;
                wd_o = ov_reg;
                wd_u = ov_reg;
                if (pair_q > sum_reg) begin
                    we_o    = 1'b1;
                    no_next = no_reg + 1'b1;
                end else if (pair_q < sum_reg) begin
                    we_u    = 1'b1;
                    nu_next = nu_reg + 1'b1;
                end
            end
            // leftover over entries get the full threshold
            S_LEFT_O: begin
                if (cnt_reg < no_reg) begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                if (pv_reg) begin
                    we_q = 1'b1;
                    wa_q = rd_o;
                    wd_q = sum_reg;
                end
                if (cnt_reg >= no_reg && !pv_reg) begin
                    cnt_next = '0;
                end
            end
            // leftover under entries likewise
            S_LEFT_U: begin
                if (cnt_reg < nu_reg) begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                if (pv_reg) begin
                    we_q = 1'b1;
                    wa_q = rd_u;
                    wd_q = sum_reg;
                end
                if (cnt_reg >= nu_reg && !pv_reg) begin
                    built_next = 1'b1;
                end
            end
            // sample: bucket index and fraction, table read
            S_SMP_IDX: begin
                idx_next  = idx_wide[IW-1:0];
                frac_next = x_full[15:0];
            end
            // split product of fraction and weight sum
            S_SMP_MUL: begin
                q_next     = rd_q0;
                alias_next = rd_a;
                lo_next    = (FRAC_BITS+HL)'(frac_reg) * (FRAC_BITS+HL)'(sum_reg[HL-1:0]);
                hi_next    = (FRAC_BITS+HH)'(frac_reg) * (FRAC_BITS+HH)'(sum_reg[QW-1:HL]);
            end
            S_SMP_CMP: begin
                sel_next = take_idx ? idx_reg : alias_reg;
            end
            // hand result to the output register
            S_DONE: begin
                if (out_free) begin
                    out_next.sampled_index = sel_ext[7:0];
                    out_next.status        = stat_reg;
                    mv_next                = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // configuration write
        if (cfg_wr_en) begin
            ecount_next = cfg_wr_data;
            built_next  = 1'b0;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            sum_reg    <= '0;
            no_reg     <= '0;
            nu_reg     <= '0;
            built_reg  <= 1'b0;
            ecount_reg <= 9'd1;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            sum_reg    <= sum_next;
            no_reg     <= no_next;
            nu_reg     <= nu_next;
            built_reg  <= built_next;
            ecount_reg <= ecount_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        pidx_reg  <= pidx_next;
        idx_reg   <= idx_next;
        frac_reg  <= frac_next;
        q_reg     <= q_next;
        alias_reg <= alias_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ov_reg    <= ov_next;
        un_reg    <= un_next;
        stat_reg  <= stat_next;
        sel_reg   <= sel_next;
        out_reg   <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
